FILE: sv/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types, fixed-point formats and constants of the Lab distance block.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int FRAC_W      = 24;   // widened component, Q0.24
  localparam int COEF_W      = 20;   // matrix coefficient, Q0.20
  localparam int PROD_W      = 44;   // coefficient * component
  localparam int T_W         = 25;   // X/Y/Z in Q0.24, up to 1.0 inclusive
  localparam int F_W         = 21;   // companded value, Q0.21
  localparam int CBRT_STEPS  = 21;   // one result bit per stage
  localparam int CBRT_N_W    = 64;
  localparam int D_W         = 23;   // signed difference of companded values
  localparam int MAG_W       = 22;   // rounded magnitude, Q.12
  localparam int SQ_W        = 44;
  localparam int SUM_W       = 45;
  localparam int SQRT_STEPS  = 24;
  localparam int DIST_W      = 17;

  localparam int LANE_LAT    = 2 + CBRT_STEPS;
  localparam int MERGE_LAT   = 4 + SQRT_STEPS + 1;
  localparam int PIPE_LAT    = LANE_LAT + MERGE_LAT;

  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [T_W-1:0]    t_t;
  typedef logic [F_W-1:0]    f_t;
  typedef logic [DIST_W-1:0] dist_t;

  // sRGB/D65 matrix with white point normalization folded in, Q0.20
  localparam coef_t XYZ_COEF [3][3] = '{
    '{20'd455029, 20'd394485, 20'd199062},
    '{20'd223004, 20'd749891, 20'd75681},
    '{20'd18619,  20'd114785, 20'd915172}
  };

  localparam t_t          LAB_THRESHOLD = 25'd148579;
  localparam t_t          T_MAX         = 25'd16777216;
  localparam logic [18:0] LIN_SLOPE     = 19'd510329;
  localparam f_t          LIN_OFFSET    = 21'd289262;
  localparam dist_t       DIST_MAX      = 17'd131071;

  localparam logic signed [33:0] SCALE_L = 34'sd116;
  localparam logic signed [33:0] SCALE_A = 34'sd500;
  localparam logic signed [33:0] SCALE_B = 34'sd200;

endpackage

FILE: sv/lcd_if.sv
// ----------------------------------------------------------------------------
// lcd_if
// Valid/ready channels for color pair requests and distance results.
// ----------------------------------------------------------------------------
interface lcd_in_if #(parameter int COMPONENT_BITS = 16);
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red_a;
  logic [COMPONENT_BITS-1:0] green_a;
  logic [COMPONENT_BITS-1:0] blue_a;
  logic [COMPONENT_BITS-1:0] red_b;
  logic [COMPONENT_BITS-1:0] green_b;
  logic [COMPONENT_BITS-1:0] blue_b;

  modport source(output valid, red_a, green_a, blue_a, red_b, green_b, blue_b,
                 input ready);
  modport sink(input valid, red_a, green_a, blue_a, red_b, green_b, blue_b,
               output ready);
endinterface

interface lcd_out_if import lcd_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t distance;

  modport source(output valid, distance, input ready);
  modport sink(input valid, distance, output ready);
endinterface

FILE: sv/lcd_cbrt.sv
// ----------------------------------------------------------------------------
// lcd_cbrt
// Pipelined floor cube root of t * 2^39, one result bit per stage.
// ----------------------------------------------------------------------------
module lcd_cbrt import lcd_pkg::*; (
  input  logic clk,
  input  logic en,
  input  t_t   t_in,
  output f_t   root
);

  logic [F_W-1:0]      r_r   [CBRT_STEPS];
  logic [2*F_W-1:0]    sq_r  [CBRT_STEPS];
  logic [CBRT_N_W-1:0] rem_r [CBRT_STEPS];

  t_t                  t_c;
  logic [CBRT_N_W-1:0] n0;

  assign t_c = (t_in > T_MAX) ? T_MAX : t_in;
  assign n0  = {t_c, {(CBRT_N_W-T_W){1'b0}}};

  for (genvar i = 0; i < CBRT_STEPS; i++) begin : g_step
    localparam int B = CBRT_STEPS - 1 - i;
    logic [F_W-1:0]      r_p;
    logic [2*F_W-1:0]    sq_p;
    logic [CBRT_N_W-1:0] rem_p;
    logic [2*F_W+1:0]    sq3;
    logic [F_W+1:0]      r3;
    logic [65:0]         delta;
    logic                fits;

    if (i == 0) begin : g_first
      assign r_p   = '0;
      assign sq_p  = '0;
      assign rem_p = n0;
    end else begin : g_next
      assign r_p   = r_r[i-1];
      assign sq_p  = sq_r[i-1];
      assign rem_p = rem_r[i-1];
    end

    // (r+d)^3 - r^3 = 3 r^2 d + 3 r d^2 + d^3 with d = 2^B
    assign sq3   = {2'b0, sq_p} + {1'b0, sq_p, 1'b0};
    assign r3    = {2'b0, r_p} + {1'b0, r_p, 1'b0};
    assign delta = ({22'd0, sq3} << B) + ({43'd0, r3} << (2*B)) + (66'd1 << (3*B));
    assign fits  = delta <= {2'b0, rem_p};

    always_ff @(posedge clk) begin
      if (en) begin
        if (fits) begin
          r_r[i]   <= r_p | (F_W'(1) << B);
          sq_r[i]  <= sq_p + ({{(F_W-1){1'b0}}, r_p, 1'b0} << B) + ((2*F_W)'(1) << (2*B));
          rem_r[i] <= rem_p - delta[CBRT_N_W-1:0];
        end else begin
          r_r[i]   <= r_p;
          sq_r[i]  <= sq_p;
          rem_r[i] <= rem_p;
        end
      end
    end
  end

  assign root = r_r[CBRT_STEPS-1];

endmodule

FILE: sv/lcd_lane.sv
// ----------------------------------------------------------------------------
// lcd_lane
// One color: RGB to XYZ matrix, then Lab companding of each channel.
// ----------------------------------------------------------------------------
module lcd_lane import lcd_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [2:0][COMPONENT_BITS-1:0] rgb,
  output logic [2:0][F_W-1:0]            f
);

  logic [PROD_W-1:0] prod_r [3][3];
  t_t                t_r    [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[k][j] <= PROD_W'(XYZ_COEF[k][j])
                        * (PROD_W'(rgb[j]) << (FRAC_W - COMPONENT_BITS));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t_r[k] <= T_W'(((PROD_W+2)'(prod_r[k][0]) + (PROD_W+2)'(prod_r[k][1])
                      + (PROD_W+2)'(prod_r[k][2]) + (PROD_W+2)'(1 << 19)) >> 20);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_chan
    f_t                root;
    f_t                lin;
    logic [43:0]       lin_prod;
    f_t                lin_d [CBRT_STEPS];
    logic              sel_d [CBRT_STEPS];

    lcd_cbrt u_cbrt (
      .clk  (clk),
      .en   (en),
      .t_in (t_r[k]),
      .root (root)
    );

    // linear segment at and below the threshold
    assign lin_prod = 44'(t_r[k]) * 44'(LIN_SLOPE) + 44'(1 << 18);
    assign lin      = F_W'(lin_prod >> 19) + LIN_OFFSET;

    always_ff @(posedge clk) begin
      if (en) begin
        lin_d[0] <= lin;
        sel_d[0] <= t_r[k] > LAB_THRESHOLD;
        for (int s = 1; s < CBRT_STEPS; s++) begin
          lin_d[s] <= lin_d[s-1];
          sel_d[s] <= sel_d[s-1];
        end
      end
    end

    assign f[k] = sel_d[CBRT_STEPS-1] ? root : lin_d[CBRT_STEPS-1];
  end

endmodule

FILE: sv/lcd_sqrt.sv
// ----------------------------------------------------------------------------
// lcd_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lcd_sqrt import lcd_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SUM_W-1:0]      n,
  output logic [SQRT_STEPS-1:0] root
);

  logic [SQRT_STEPS-1:0] r_r   [SQRT_STEPS];
  logic [SUM_W-1:0]      rem_r [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam int B = SQRT_STEPS - 1 - i;
    logic [SQRT_STEPS-1:0] r_p;
    logic [SUM_W-1:0]      rem_p;
    logic [49:0]           delta;
    logic                  fits;

    if (i == 0) begin : g_first
      assign r_p   = '0;
      assign rem_p = n;
    end else begin : g_next
      assign r_p   = r_r[i-1];
      assign rem_p = rem_r[i-1];
    end

    // (r+d)^2 - r^2 = 2 r d + d^2
    assign delta = ({26'd0, r_p} << (B + 1)) + (50'd1 << (2*B));
    assign fits  = delta <= {5'b0, rem_p};

    always_ff @(posedge clk) begin
      if (en) begin
        if (fits) begin
          r_r[i]   <= r_p | (SQRT_STEPS'(1) << B);
          rem_r[i] <= rem_p - delta[SUM_W-1:0];
        end else begin
          r_r[i]   <= r_p;
          rem_r[i] <= rem_p;
        end
      end
    end
  end

  assign root = r_r[SQRT_STEPS-1];

endmodule

FILE: sv/lcd_merge.sv
// ----------------------------------------------------------------------------
// lcd_merge
// Combines both lanes: Lab differences, squares, root, rounding, saturation.
// ----------------------------------------------------------------------------
module lcd_merge import lcd_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0][F_W-1:0] fa,
  input  logic [2:0][F_W-1:0] fb,
  output dist_t               distance
);

  logic signed [D_W-1:0]  d_l_r, d_a_r, d_b_r;
  logic [MAG_W-1:0]       mag_l_r, mag_a_r, mag_b_r;
  logic [SQ_W-1:0]        sq_l_r, sq_a_r, sq_b_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SQRT_STEPS-1:0]  root;
  logic [SQRT_STEPS:0]    rnd;
  dist_t                  dist_r;
  logic signed [D_W-1:0]  dx, dy, dz;

  function automatic logic [MAG_W-1:0] mag_q12(input logic signed [33:0] p);
    logic [33:0] u;
    u = p[33] ? 34'(-p) : 34'(p);
    return MAG_W'((u + 34'd256) >> 9);
  endfunction

  assign dx = D_W'($signed({1'b0, fa[0]})) - D_W'($signed({1'b0, fb[0]}));
  assign dy = D_W'($signed({1'b0, fa[1]})) - D_W'($signed({1'b0, fb[1]}));
  assign dz = D_W'($signed({1'b0, fa[2]})) - D_W'($signed({1'b0, fb[2]}));

  always_ff @(posedge clk) begin
    if (en) begin
      d_l_r   <= dy;
      d_a_r   <= dx - dy;
      d_b_r   <= dy - dz;
      mag_l_r <= mag_q12(34'(d_l_r) * SCALE_L);
      mag_a_r <= mag_q12(34'(d_a_r) * SCALE_A);
      mag_b_r <= mag_q12(34'(d_b_r) * SCALE_B);
      sq_l_r  <= SQ_W'(mag_l_r) * SQ_W'(mag_l_r);
      sq_a_r  <= SQ_W'(mag_a_r) * SQ_W'(mag_a_r);
      sq_b_r  <= SQ_W'(mag_b_r) * SQ_W'(mag_b_r);
      sum_r   <= SUM_W'(sq_l_r) + SUM_W'(sq_a_r) + SUM_W'(sq_b_r);
    end
  end

  lcd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (sum_r),
    .root (root)
  );

  // Q.12 root rounded half up to Q.8
  assign rnd = ((SQRT_STEPS+1)'(root) + (SQRT_STEPS+1)'(8)) >> 4;

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (rnd > (SQRT_STEPS+1)'(DIST_MAX)) ? DIST_MAX : DIST_W'(rnd);
    end
  end

  assign distance = dist_r;

endmodule

FILE: sv/lab_color_distance.sv
// ----------------------------------------------------------------------------
// lab_color_distance
// CIE76 delta E between two linear RGB colors, fully pipelined.
// ----------------------------------------------------------------------------
// Each request carries two linear RGB colors (unsigned Q0.COMPONENT_BITS).
// Two identical lanes, one per color, map RGB to white-normalized XYZ and
// apply the Lab companding; a merge stage forms the Lab differences, their
// squares and the square root, and returns delta E in unsigned Q9.8,
// saturating at 131071. The block takes one request per clock cycle while
// the output is not held, and passes each request through 2 matrix
// stages, 21 cube root stages (one bit each), 4 difference/square/sum
// stages, 24 square root stages and the output register. The pipeline
// advances as a whole; when a result is waiting and not taken, all stages
// hold and in_req.ready drops, so bubbles already in the pipe stay where
// they are. in_req.ready is low during reset.
// There is no state between requests and nothing to configure.
// ----------------------------------------------------------------------------
module lab_color_distance import lcd_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lcd_in_if.sink    in_req,
  lcd_out_if.source out_res
);

  logic                      en;
  logic [PIPE_LAT-1:0]       vld_r;
  logic [PIPE_LAT-1:0]       vld_nxt;
  logic [2:0][F_W-1:0]       fa, fb;

  // whole pipe moves unless the output holds an untaken result
  assign en           = out_res.ready | ~vld_r[PIPE_LAT-1];
  assign in_req.ready = en & rst_n;

  assign vld_nxt = en ? {vld_r[PIPE_LAT-2:0], in_req.valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // lane for the first color
  lcd_lane #(.COMPONENT_BITS(COMPONENT_BITS)) u_lane_a (
    .clk (clk),
    .en  (en),
    .rgb ({in_req.blue_a, in_req.green_a, in_req.red_a}),
    .f   (fa)
  );

  // lane for the second color
  lcd_lane #(.COMPONENT_BITS(COMPONENT_BITS)) u_lane_b (
    .clk (clk),
    .en  (en),
    .rgb ({in_req.blue_b, in_req.green_b, in_req.red_b}),
    .f   (fb)
  );

  // differences, squares, root and the output register
  lcd_merge u_merge (
    .clk      (clk),
    .en       (en),
    .fa       (fa),
    .fb       (fb),
    .distance (out_res.distance)
  );

  assign out_res.valid = vld_r[PIPE_LAT-1];

endmodule
